@@ src/rph_pkg.sv @@
// Shared types, constants and stage functions for the roll, pitch and heading pipeline.
`default_nettype none
package rph_pkg;

  localparam int SW        = 31;
  localparam int XW        = 34;
  localparam int ZW        = 32;
  localparam int NW        = 60;
  localparam int RW        = 30;
  localparam int REMW      = 34;
  localparam int FINE_BITS = 12;
  localparam int TAB_LEN   = 24;

  localparam logic signed [ZW-1:0] HALF_FINE = 32'sd73728000;
  localparam logic signed [ZW-1:0] ROUND_HALF = 32'sd2048;
  localparam logic signed [ZW-1:0] LIM_HALF = 32'sd18000;
  localparam logic signed [ZW-1:0] LIM_QUARTER = 32'sd9000;
  localparam logic signed [15:0] DECL_RESET = -16'sd62;

  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    32'sd18432000, 32'sd10881045, 32'sd5749245, 32'sd2918407, 32'sd1464867,
    32'sd733147, 32'sd366663, 32'sd183343, 32'sd91673, 32'sd45837, 32'sd22918,
    32'sd11459, 32'sd5730, 32'sd2865, 32'sd1432, 32'sd716, 32'sd358, 32'sd179,
    32'sd90, 32'sd45, 32'sd22, 32'sd11, 32'sd6, 32'sd3
  };

  typedef struct packed {
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic signed [SW-1:0] az;
    logic signed [SW-1:0] mx;
    logic signed [SW-1:0] my;
  } samp_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
    logic [NW-1:0]   n;
  } sqrt_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic roll_zero;
    logic pitch_zero;
    logic head_fix;
    logic head_half;
  } flags_t;

  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t           r;
    logic [REMW-1:0] rs;
    logic [REMW-1:0] t;
    rs = {s.rem[REMW-3:0], s.n[NW-1:NW-2]};
    t  = REMW'({s.root, 2'b01});
    r.n = {s.n[NW-3:0], 2'b00};
    if (rs >= t) begin
      r.rem  = rs - t;
      r.root = {s.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {s.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic cordic_t prerot(logic signed [XW-1:0] y, logic signed [XW-1:0] x);
    cordic_t c;
    if (x < 0) begin
      c.x = -x;
      c.y = -y;
      c.z = (y >= 0) ? HALF_FINE : -HALF_FINE;
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  function automatic cordic_t cordic_step(cordic_t c, int i);
    cordic_t              r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ATAN_TAB[i];
    end else begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ATAN_TAB[i];
    end
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] to_cd(logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    if (z >= 0) begin
      r = (z + ROUND_HALF) >>> FINE_BITS;
    end else begin
      r = -((-z + ROUND_HALF) >>> FINE_BITS);
    end
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] clamp(logic signed [ZW-1:0] v,
                                                 logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/roll_pitch_heading_from_accel_mag_unit.sv @@
// Top level: pipelined roll, pitch and heading from accelerometer and magnetometer words.
//
// Input channel in_valid/in_ready carries one word of accel_x, accel_y, accel_z, mag_x and
// mag_y. Output channel out_valid/out_ready returns heading_centideg, pitch_centideg and
// roll_centideg in hundredths of a degree. Configuration channel cfg_valid/cfg_ready
// writes declination_centideg (reset -62), subtracted from the heading; write it idle.
// One word is accepted per cycle unless the output stalls. The stages are one input
// register, a squaring stage, a sum stage, thirty square-root stages (one result bit
// each), a pre-rotation stage, CORDIC_STAGES vectoring stages shared in lockstep by the
// three angles, a wrap stage and the output register.
// Reset clears every valid bit and loads the declination reset value.
// When the receiver stalls, the whole pipeline holds and in_ready drops; nothing
// is lost or repeated. in_ready is high whenever the output register is empty or taken.
`default_nettype none
module roll_pitch_heading_from_accel_mag_unit #(
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] mag_x,
  input  wire logic signed [15:0] mag_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      heading_centideg,
  output logic signed [14:0]      pitch_centideg,
  output logic signed [15:0]      roll_centideg,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [15:0] declination_centideg
);
  import rph_pkg::*;

  localparam int EW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int SHIFT = 30 - SAMPLE_BITS;
  localparam int SQ    = RW;
  localparam int CS    = CORDIC_STAGES;

  logic adv;
  logic signed [15:0] decl;

  logic              v0;
  samp_t             s0;
  logic              v1;
  samp_t             s1;
  logic [NW-2:0]     sqy1;
  logic [NW-2:0]     sqz1;
  logic              v2;
  samp_t             s2;
  logic [NW-1:0]     n2;
  logic              sqv [SQ];
  samp_t             sqs [SQ];
  sqrt_t             sqr [SQ];
  logic              cv  [CS+1];
  flags_t            cf  [CS+1];
  cordic_t           cro [CS+1];
  cordic_t           cpi [CS+1];
  cordic_t           chd [CS+1];
  logic              fv;
  logic signed [ZW-1:0] f_roll;
  logic signed [ZW-1:0] f_pitch;
  logic signed [ZW-1:0] f_head;

  samp_t             s_in;
  sqrt_t             sq_first;
  logic signed [2*SW-1:0] py;
  logic signed [2*SW-1:0] pz;
  flags_t            flags_p;
  logic [RW-1:0]     r_last;
  logic signed [ZW-1:0] head_fine;
  logic signed [ZW-1:0] head_dec;
  logic signed [ZW-1:0] head_wrap;

  function automatic logic signed [SW-1:0] scale(logic signed [15:0] p);
    logic [EW-1:0]          e;
    logic [SAMPLE_BITS-1:0] raw;
    e   = EW'($unsigned(p));
    raw = e[SAMPLE_BITS-1:0];
    return $signed({{(SW-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw}) <<< SHIFT;
  endfunction

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    s_in.ax = scale(accel_x);
    s_in.ay = scale(accel_y);
    s_in.az = scale(accel_z);
    s_in.mx = -scale(mag_x);
    s_in.my = -scale(mag_y);
    py = s0.ay * s0.ay;
    pz = s0.az * s0.az;
    sq_first = sqrt_step('{rem: '0, root: '0, n: n2});
    r_last = sqr[SQ-1].root;
    flags_p.roll_zero  = (sqs[SQ-1].ay == 0) && (sqs[SQ-1].az == 0);
    flags_p.pitch_zero = (sqs[SQ-1].ax == 0) && (r_last == 0);
    flags_p.head_fix   = (sqs[SQ-1].my == 0);
    flags_p.head_half  = sqs[SQ-1].mx < 0;
    if (cf[CS].head_fix) begin
      head_fine = cf[CS].head_half ? HALF_FINE : '0;
    end else begin
      head_fine = chd[CS].z;
    end
    head_dec = head_fine - ({{(ZW-16){decl[15]}}, decl} <<< FINE_BITS);
    if (head_dec > HALF_FINE) begin
      head_wrap = head_dec - (HALF_FINE <<< 1);
    end else if (head_dec < -HALF_FINE) begin
      head_wrap = head_dec + (HALF_FINE <<< 1);
    end else begin
      head_wrap = head_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= DECL_RESET;
    end else if (cfg_valid) begin
      decl <= declination_centideg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int j = 0; j < SQ; j++) begin
        sqv[j] <= 1'b0;
      end
      for (int i = 0; i <= CS; i++) begin
        cv[i] <= 1'b0;
      end
      fv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      sqv[0] <= v2;
      for (int j = 1; j < SQ; j++) begin
        sqv[j] <= sqv[j-1];
      end
      cv[0] <= sqv[SQ-1];
      for (int i = 1; i <= CS; i++) begin
        cv[i] <= cv[i-1];
      end
      fv        <= cv[CS];
      out_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0   <= s_in;
      s1   <= s0;
      sqy1 <= py[NW-2:0];
      sqz1 <= pz[NW-2:0];
      s2   <= s1;
      n2   <= NW'(sqy1) + NW'(sqz1);
      sqs[0] <= s2;
      sqr[0] <= sq_first;
      for (int j = 1; j < SQ; j++) begin
        sqs[j] <= sqs[j-1];
        sqr[j] <= sqrt_step(sqr[j-1]);
      end
      cf[0]  <= flags_p;
      cro[0] <= prerot(XW'(sqs[SQ-1].ay), XW'(sqs[SQ-1].az));
      cpi[0] <= prerot(-XW'(sqs[SQ-1].ax), XW'(r_last));
      chd[0] <= prerot(XW'(sqs[SQ-1].mx), XW'(sqs[SQ-1].my));
      for (int i = 1; i <= CS; i++) begin
        cf[i]  <= cf[i-1];
        cro[i] <= cordic_step(cro[i-1], i - 1);
        cpi[i] <= cordic_step(cpi[i-1], i - 1);
        chd[i] <= cordic_step(chd[i-1], i - 1);
      end
      f_roll  <= cf[CS].roll_zero ? '0 : clamp(to_cd(cro[CS].z), LIM_HALF);
      f_pitch <= cf[CS].pitch_zero ? '0 : clamp(to_cd(cpi[CS].z), LIM_QUARTER);
      f_head  <= head_wrap;
      roll_centideg    <= f_roll[15:0];
      pitch_centideg   <= f_pitch[14:0];
      heading_centideg <= 16'(clamp(to_cd(f_head), LIM_HALF));
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pitch_centideg <= 15'sd9000) && (pitch_centideg >= -15'sd9000)))
    else $error("pitch out of range");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((heading_centideg <= 16'sd18000) && (heading_centideg >= -16'sd18000)))
    else $error("heading out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((roll_centideg <= 16'sd18000) && (roll_centideg >= -16'sd18000)))
    else $error("roll out of range");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the roll, pitch and heading unit: directed and random sensor words checked against a local angle predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = 16;
  localparam int STAGES      = 18;
  localparam int LATENCY     = 36 + STAGES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 150;
  localparam longint FINE_CD = 4096;
  localparam longint HALF_TURN = 64'sd18000 * FINE_CD;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, mag_x = '0, mag_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] heading_centideg;
  logic signed [14:0] pitch_centideg;
  logic signed [15:0] roll_centideg;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [15:0] declination_centideg = '0;

  angles_t expected_angles[$];
  longint decl_model = -62;
  int errors = 0;
  longint cycles = 0;
  bit rx_idle_on = 1'b1;
  int rx_hold = 0;
  bit long_hold_req = 1'b0;
  logic long_hold = 1'b0;

  always #1 clk = ~clk;

  roll_pitch_heading_from_accel_mag_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .mag_x(mag_x), .mag_y(mag_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .heading_centideg(heading_centideg), .pitch_centideg(pitch_centideg),
    .roll_centideg(roll_centideg),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .declination_centideg(declination_centideg)
  );

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    longint tab[24] = '{18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663,
                        183343, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358,
                        179, 90, 45, 22, 11, 6, 3};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += tab[i];
      end else begin
        x -= dx; y += dy; z -= tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint fine_to_cd(longint z);
    if (z >= 0) return (z + FINE_CD / 2) >>> 12;
    return -((-z + FINE_CD / 2) >>> 12);
  endfunction

  function automatic longint limit(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] ax16, logic signed [15:0] ay16,
                                             logic signed [15:0] az16, logic signed [15:0] mx16,
                                             logic signed [15:0] my16);
    angles_t a;
    longint sc, ax, ay, az, mx, my, r, hd;
    longint unsigned ss;
    sc = 64'sd1 << (30 - SAMPLE_BITS);
    ax = ax16; ay = ay16; az = az16;
    mx = -longint'(mx16);
    my = -longint'(my16);
    a.roll = 16'(limit(fine_to_cd(vector_angle(ay * sc, az * sc)), 18000));
    ss = (unsigned'(ay * ay) + unsigned'(az * az)) << (2 * (30 - SAMPLE_BITS));
    r = int_sqrt(ss);
    a.pitch = 15'(limit(fine_to_cd(vector_angle(-ax * sc, r)), 9000));
    if (my == 0) hd = (mx < 0) ? HALF_TURN : 0;
    else hd = vector_angle(mx * sc, my * sc);
    hd -= decl_model * FINE_CD;
    if (hd > HALF_TURN) hd -= 2 * HALF_TURN;
    else if (hd < -HALF_TURN) hd += 2 * HALF_TURN;
    a.heading = 16'(limit(fine_to_cd(hd), 18000));
    return a;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // hold off the receiver for a long stretch on request
  always begin
    wait (long_hold_req);
    @(posedge clk);
    long_hold_req = 1'b0;
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  // receiver: random stalls unless disabled, plus a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      rx_hold <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    angles_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        $display("%0t unexpected word h=%0d p=%0d r=%0d", $time, heading_centideg,
                 pitch_centideg, roll_centideg);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (heading_centideg !== e.heading) begin
          $display("%0t heading expected %0d actual %0d", $time, e.heading, heading_centideg);
          errors++;
        end
        if (pitch_centideg !== e.pitch) begin
          $display("%0t pitch expected %0d actual %0d", $time, e.pitch, pitch_centideg);
          errors++;
        end
        if (roll_centideg !== e.roll) begin
          $display("%0t roll expected %0d actual %0d", $time, e.roll, roll_centideg);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic signed [15:0] mx,
                             logic signed [15:0] my, bit gaps);
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax; accel_y <= ay; accel_z <= az; mag_x <= mx; mag_y <= my;
    expected_angles.push_back(predict_angles(ax, ay, az, mx, my));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_declination(logic signed [15:0] d);
    drain();
    cfg_valid <= 1'b1;
    declination_centideg <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    decl_model = d;
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 8)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    logic signed [15:0] ext[5] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1};
    send_sample(0, 0, 0, 0, 0, 1'b0);
    send_sample(0, 0, 0, 16'sd5, 0, 1'b0);
    send_sample(0, 0, 0, -16'sd5, 0, 1'b0);
    send_sample(16'sd100, 0, -16'sd100, 0, 16'sd7, 1'b0);
    send_sample(0, -16'sd1, -16'sd100, 16'sd3, -16'sd9, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    for (int i = 0; i < 5; i++)
      send_sample(ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5], ext[(i + 3) % 5],
                  ext[(i + 4) % 5], 1'b1);
    send_sample(0, 16'sd1, 16'sh8000, 16'sd1, 16'sh8000, 1'b1);
    send_sample(0, -16'sd1, 16'sh8000, -16'sd1, 16'sh8000, 1'b1);
  endtask

  task automatic test_declination;
    logic signed [15:0] vals[5] = '{16'sd18000, -16'sd18000, 16'sd0, 16'sh7FFF, 16'sh8000};
    foreach (vals[k]) begin
      write_declination(vals[k]);
      repeat (12) send_sample(rand_word(), rand_word(), rand_word(), rand_word(),
                              rand_word(), 1'b1);
    end
  endtask

  task automatic test_backpressure;
    write_declination(-16'sd62);
    long_hold_req = 1'b1;
    repeat (90) send_sample(rand_word(), rand_word(), rand_word(), rand_word(),
                            rand_word(), 1'b0);
    drain();
  endtask

  task automatic test_random;
    for (int n = 0; n < 450; n++) begin
      if (n % 150 == 149) write_declination(16'($signed($urandom_range(0, 36000)) - 18000));
      send_sample(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
    end
  endtask

  task automatic test_full_rate;
    rx_idle_on = 1'b0;
    repeat (60) send_sample(rand_word(), rand_word(), rand_word(), rand_word(),
                            rand_word(), 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_declination();
    test_backpressure();
    test_random();
    test_full_rate();
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
